// ----- rtl/imuid_pkg.sv -----
package imuid_pkg;

  // default number of fraction bits of a magnitude
  localparam int FractionBits = 8;

  // raw accelerometer reading of one g
  localparam int OneGRaw = 2048;

  // width of a sum of three squared 16-bit readings
  localparam int SumW = 32;

  localparam int MagW = 24;
  localparam int HoldW = 16;
  localparam int TimeW = 32;
  localparam int CountW = 32;

  // item queue between front and back
  localparam int QueueDepth = 2;

  // item kinds
  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindFault  = 2'd1;
  localparam logic [1:0] KindReport = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgJerkThreshold     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRotationThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHitHoldMs         = 2'd2;

  localparam logic [MagW-1:0]  JerkThresholdReset     = 24'd1572864;
  localparam logic [MagW-1:0]  RotationThresholdReset = 24'd2515200;
  localparam logic [HoldW-1:0] HitHoldMsReset         = 16'd500;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [TimeW-1:0]  now_ms;
  } imuid_in_t;

  typedef struct packed {
    logic [MagW-1:0]   peak_jerk;
    logic [MagW-1:0]   peak_rotation;
    logic              hit_active;
    logic              read_fault;
    logic [CountW-1:0] report_number;
  } imuid_out_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [MagW-1:0]    data;
  } imuid_cfg_t;

endpackage

// ----- rtl/imuid_front.sv -----
module imuid_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  imuid_pkg::imuid_in_t in_data_i,
  output logic                 head_valid_o,
  output imuid_pkg::imuid_in_t head_o,
  input  logic                 pop_i
);

  localparam int Depth = imuid_pkg::QueueDepth;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  imuid_pkg::imuid_in_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  assign in_ready_o   = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // unused kind code is taken and dropped here
  assign push = in_valid_i && in_ready_o && (in_data_i.kind != imuid_pkg::KindUnused);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

endmodule

// ----- rtl/imuid_sqrt.sv -----
module imuid_sqrt #(
  parameter int FRACTION_BITS = imuid_pkg::FractionBits
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  input  logic [imuid_pkg::SumW+2*FRACTION_BITS-1:0]      radicand_i,
  output logic                                            done_o,
  output logic [imuid_pkg::MagW-1:0]                      mag_o
);

  localparam int RadW  = imuid_pkg::SumW + 2 * FRACTION_BITS;
  localparam int RootW = RadW / 2;
  localparam int StepW = $clog2(RootW);

  logic [RadW-1:0]    rad_q, rad_d;
  logic [RootW+1:0]   rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RootW+3:0]   rem_sh;
  logic [RootW+3:0]   trial;
  logic [RootW+3:0]   diff;
  logic [31:0]        root_ext;

  // one result bit per cycle, restoring method
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      step_d = StepW'(RootW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = diff[RootW+1:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RootW+1:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    step_q <= step_d;
  end

  // saturate at the magnitude width
  assign root_ext = 32'(root_q);
  assign mag_o    = (root_ext > 32'(24'hFFFFFF)) ? '1 : root_ext[imuid_pkg::MagW-1:0];
  assign done_o   = done_q;

endmodule

// ----- rtl/imuid_back.sv -----
module imuid_back #(
  parameter int FRACTION_BITS = imuid_pkg::FractionBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imuid_pkg::imuid_cfg_t cfg_i,
  input  logic                  head_valid_i,
  input  imuid_pkg::imuid_in_t  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output imuid_pkg::imuid_out_t out_data_o
);

  localparam int MagW  = imuid_pkg::MagW;
  localparam int SumW  = imuid_pkg::SumW;
  localparam int RadW  = SumW + 2 * FRACTION_BITS;
  localparam logic [MagW-1:0] OneG = MagW'(imuid_pkg::OneGRaw << FRACTION_BITS);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SSq   = 3'd1;
  localparam logic [2:0] SRt   = 3'd2;
  localparam logic [2:0] SJerk = 3'd3;
  localparam logic [2:0] SUpd  = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [1:0]                      cnt_q, cnt_d;
  logic                            vsel_q, vsel_d;
  logic [SumW-1:0]                 sum_q, sum_d;
  logic [MagW-1:0]                 am_q, am_d;
  logic [MagW-1:0]                 gm_q, gm_d;
  logic [MagW-1:0]                 jerk_q, jerk_d;
  logic [MagW-1:0]                 last_am_q, last_am_d;
  logic [MagW-1:0]                 peak_jerk_q, peak_jerk_d;
  logic [MagW-1:0]                 peak_rot_q, peak_rot_d;
  logic [imuid_pkg::TimeW-1:0]     hit_time_q, hit_time_d;
  logic                            fault_q, fault_d;
  logic [imuid_pkg::CountW-1:0]    rpt_q, rpt_d;
  logic [MagW-1:0]                 jerk_thr_q, jerk_thr_d;
  logic [MagW-1:0]                 rot_thr_q, rot_thr_d;
  logic [imuid_pkg::HoldW-1:0]     hold_q, hold_d;
  logic                            out_valid_q, out_valid_d;
  imuid_pkg::imuid_out_t           out_q, out_d;

  logic signed [15:0]              mul_op;
  logic signed [31:0]              sq;
  logic [imuid_pkg::TimeW-1:0]     elapsed;
  logic                            sqrt_start;
  logic [RadW-1:0]                 radicand;
  logic                            sqrt_done;
  logic [MagW-1:0]                 sqrt_mag;
  logic                            pop;

  imuid_sqrt #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i(radicand),
    .done_o    (sqrt_done),
    .mag_o     (sqrt_mag)
  );

  // one squarer, accel x y z then gyro x y z
  always_comb begin
    unique case ({vsel_q, cnt_q})
      3'd0:    mul_op = head_i.accel_x;
      3'd1:    mul_op = head_i.accel_y;
      3'd2:    mul_op = head_i.accel_z;
      3'd4:    mul_op = head_i.gyro_x;
      3'd5:    mul_op = head_i.gyro_y;
      3'd6:    mul_op = head_i.gyro_z;
      default: mul_op = '0;
    endcase
  end

  assign sq      = mul_op * mul_op;
  assign elapsed = head_i.now_ms - hit_time_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    vsel_d      = vsel_q;
    sum_d       = sum_q;
    am_d        = am_q;
    gm_d        = gm_q;
    jerk_d      = jerk_q;
    last_am_d   = last_am_q;
    peak_jerk_d = peak_jerk_q;
    peak_rot_d  = peak_rot_q;
    hit_time_d  = hit_time_q;
    fault_d     = fault_q;
    rpt_d       = rpt_q;
    jerk_thr_d  = jerk_thr_q;
    rot_thr_d   = rot_thr_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop         = 1'b0;
    sqrt_start  = 1'b0;
    radicand    = '0;

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        imuid_pkg::CfgJerkThreshold:     jerk_thr_d = cfg_i.data;
        imuid_pkg::CfgRotationThreshold: rot_thr_d  = cfg_i.data;
        imuid_pkg::CfgHitHoldMs:         hold_d     = cfg_i.data[imuid_pkg::HoldW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      SIdle: begin
        if (head_valid_i) begin
          unique case (head_i.kind)
            imuid_pkg::KindSample: begin
              state_d = SSq;
              cnt_d   = '0;
              vsel_d  = 1'b0;
              sum_d   = '0;
            end
            imuid_pkg::KindFault: begin
              fault_d = 1'b1;
              pop     = 1'b1;
            end
            imuid_pkg::KindReport: begin
              if (!out_valid_q || out_ready_i) begin
                out_valid_d         = 1'b1;
                out_d.peak_jerk     = peak_jerk_q;
                out_d.peak_rotation = peak_rot_q;
                out_d.hit_active    = (elapsed < 32'(hold_q));
                out_d.read_fault    = fault_q;
                out_d.report_number = rpt_q;
                rpt_d               = rpt_q + 1'b1;
                peak_jerk_d         = '0;
                peak_rot_d          = '0;
                fault_d             = 1'b0;
                pop                 = 1'b1;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      SSq: begin
        sum_d = sum_q + $unsigned(sq);
        if (cnt_q == 2'd2) begin
          sqrt_start = 1'b1;
          radicand   = RadW'(sum_d) << (2 * FRACTION_BITS);
          state_d    = SRt;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      SRt: begin
        if (sqrt_done) begin
          if (!vsel_q) begin
            am_d    = sqrt_mag;
            vsel_d  = 1'b1;
            cnt_d   = '0;
            sum_d   = '0;
            state_d = SSq;
          end else begin
            gm_d    = sqrt_mag;
            state_d = SJerk;
          end
        end
      end
      SJerk: begin
        jerk_d  = (am_q >= last_am_q) ? am_q - last_am_q : last_am_q - am_q;
        state_d = SUpd;
      end
      SUpd: begin
        last_am_d = am_q;
        if (jerk_q > peak_jerk_q) begin
          peak_jerk_d = jerk_q;
        end
        if (gm_q > peak_rot_q) begin
          peak_rot_d = gm_q;
        end
        if (jerk_q > jerk_thr_q && gm_q < rot_thr_q) begin
          hit_time_d = head_i.now_ms;
        end
        pop     = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      vsel_q      <= 1'b0;
      last_am_q   <= OneG;
      peak_jerk_q <= '0;
      peak_rot_q  <= '0;
      hit_time_q  <= '0;
      fault_q     <= 1'b0;
      rpt_q       <= '0;
      jerk_thr_q  <= imuid_pkg::JerkThresholdReset;
      rot_thr_q   <= imuid_pkg::RotationThresholdReset;
      hold_q      <= imuid_pkg::HitHoldMsReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      vsel_q      <= vsel_d;
      last_am_q   <= last_am_d;
      peak_jerk_q <= peak_jerk_d;
      peak_rot_q  <= peak_rot_d;
      hit_time_q  <= hit_time_d;
      fault_q     <= fault_d;
      rpt_q       <= rpt_d;
      jerk_thr_q  <= jerk_thr_d;
      rot_thr_q   <= rot_thr_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    am_q   <= am_d;
    gm_q   <= gm_d;
    jerk_q <= jerk_d;
    out_q  <= out_d;
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == SRt)
    else $error("root unit finished outside the root state");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> head_valid_i)
    else $error("sample lost its queue entry while in work");

  a_idle_pop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && state_q == SIdle) |-> (head_valid_i && head_i.kind != imuid_pkg::KindSample))
    else $error("sample popped before it was processed");

  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && state_q == SIdle && head_i.kind == imuid_pkg::KindReport)
      |=> (peak_jerk_q == '0 && peak_rot_q == '0 && !fault_q && out_valid_q))
    else $error("window not cleared after report");

endmodule

// ----- rtl/imu_impact_detector.sv -----
// Impact detector for raw 3-axis accelerometer and gyroscope samples. Items enter a
// two-entry queue and are carried out in order by a back end with one shared squarer
// and one shared root unit that yields one result bit per cycle. A sample passes through
// the squarer and the root unit twice, once for the accelerometer and once for the
// gyroscope vector; a read-failure or report item is handled in the idle state, a
// report waiting only while the previous report has not been transferred. Kind 3 is
// dropped on entry. Configuration writes are always taken (cfg_ready_o is tied high)
// and are meant to be issued while the block is idle.
module imu_impact_detector #(
  parameter int FRACTION_BITS = imuid_pkg::FractionBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  imuid_pkg::imuid_in_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output imuid_pkg::imuid_out_t           out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [imuid_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [imuid_pkg::MagW-1:0]      cfg_data_i
);

  imuid_pkg::imuid_in_t  head;
  imuid_pkg::imuid_cfg_t cfg;
  logic                  head_valid;
  logic                  pop;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  imuid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  imuid_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/imu_impact_detector_test.sv -----
`timescale 1ns / 100ps

module imu_impact_detector_test;

  localparam int MagW = imuid_pkg::MagW;
  localparam int HoldW = imuid_pkg::HoldW;
  localparam int TimeW = imuid_pkg::TimeW;
  localparam int CountW = imuid_pkg::CountW;
  localparam int CfgIdxW = imuid_pkg::CfgIdxW;
  localparam int FractionBits = imuid_pkg::FractionBits;

  localparam int SettleCycles = 150;
  localparam int IdleLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int ItemsPerPhase = 213;
  localparam int PhaseCount = 6;
  localparam int MaxShown = 10;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  imuid_pkg::imuid_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  imuid_pkg::imuid_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [MagW-1:0] cfg_data_i = '0;

  imu_impact_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // detector state as predicted
  logic [MagW-1:0] jerk_limit = imuid_pkg::JerkThresholdReset;
  logic [MagW-1:0] rotation_limit = imuid_pkg::RotationThresholdReset;
  logic [HoldW-1:0] hold_limit = imuid_pkg::HitHoldMsReset;
  logic [MagW-1:0] prev_accel_len = MagW'(imuid_pkg::OneGRaw << FractionBits);
  logic [MagW-1:0] worst_jerk = '0;
  logic [MagW-1:0] worst_rotation = '0;
  logic [TimeW-1:0] hit_stamp = '0;
  logic fault_flag = 1'b0;
  logic [CountW-1:0] report_seq = '0;

  imuid_pkg::imuid_in_t pending_items[$];
  imuid_pkg::imuid_out_t expected_reports[$];

  int errors = 0;
  int reports_seen = 0;
  int items_made = 0;
  int quiet_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  int hold_asked = 0;
  int hold_served = 0;
  bit in_xfer = 1'b0;
  bit idle_on = 1'b1;
  logic [TimeW-1:0] clock_ms = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor of the square root, one result bit at a time from the top
  function automatic logic [MagW-1:0] vector_length(input logic signed [15:0] x,
                                                    input logic signed [15:0] y,
                                                    input logic signed [15:0] z);
    longint sq;
    logic [63:0] scaled, root, trial;
    sq = longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
    scaled = 64'(sq) << (2 * FractionBits);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    return (root > 64'(24'hFF_FFFF)) ? '1 : root[MagW-1:0];
  endfunction

  task automatic track_item(input imuid_pkg::imuid_in_t it);
    logic [MagW-1:0] a_len, g_len, jerk;
    logic [TimeW-1:0] elapsed;
    imuid_pkg::imuid_out_t rep;
    case (it.kind)
      imuid_pkg::KindSample: begin
        a_len = vector_length(it.accel_x, it.accel_y, it.accel_z);
        g_len = vector_length(it.gyro_x, it.gyro_y, it.gyro_z);
        jerk = (a_len >= prev_accel_len) ? a_len - prev_accel_len : prev_accel_len - a_len;
        prev_accel_len = a_len;
        if (jerk > worst_jerk) worst_jerk = jerk;
        if (g_len > worst_rotation) worst_rotation = g_len;
        if (jerk > jerk_limit && g_len < rotation_limit) hit_stamp = it.now_ms;
      end
      imuid_pkg::KindFault: begin
        fault_flag = 1'b1;
      end
      imuid_pkg::KindReport: begin
        elapsed = it.now_ms - hit_stamp;
        rep.peak_jerk = worst_jerk;
        rep.peak_rotation = worst_rotation;
        rep.hit_active = (elapsed < TimeW'(hold_limit));
        rep.read_fault = fault_flag;
        rep.report_number = report_seq;
        expected_reports.push_back(rep);
        report_seq++;
        worst_jerk = '0;
        worst_rotation = '0;
        fault_flag = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MaxShown)
        $display("report %0d: %s expected %0h got %0h", reports_seen, field, want, got);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_xfer)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    in_xfer = 1'b0;
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        quiet_cycles = 0;
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= MaxShown) $display("report %0d: no report expected", reports_seen);
        end else begin
          flag_field("peak_jerk", expected_reports[0].peak_jerk, out_data_o.peak_jerk);
          flag_field("peak_rotation", expected_reports[0].peak_rotation,
                     out_data_o.peak_rotation);
          flag_field("hit_active", expected_reports[0].hit_active, out_data_o.hit_active);
          flag_field("read_fault", expected_reports[0].read_fault, out_data_o.read_fault);
          flag_field("report_number", expected_reports[0].report_number,
                     out_data_o.report_number);
          void'(expected_reports.pop_front());
        end
        reports_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        quiet_cycles = 0;
        in_xfer = 1'b1;
        track_item(in_data_i);
      end
      if (cfg_valid_i && cfg_ready_o) quiet_cycles = 0;
      if (quiet_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MagW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      imuid_pkg::CfgJerkThreshold: jerk_limit = value;
      imuid_pkg::CfgRotationThreshold: rotation_limit = value;
      imuid_pkg::CfgHitHoldMs: hold_limit = value[HoldW-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offer(input imuid_pkg::imuid_in_t it);
    pending_items.push_back(it);
    if (it.kind != imuid_pkg::KindUnused) items_made++;
  endtask

  // random payload, used where the fields do not matter or for full-range samples
  task automatic offer_plain(input logic [1:0] kind, input logic [TimeW-1:0] now);
    logic [159:0] noise;
    imuid_pkg::imuid_in_t it;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(imuid_pkg::imuid_in_t)-1:0];
    it.kind = kind;
    it.now_ms = now;
    offer(it);
  endtask

  task automatic offer_sample(input int ax, input int ay, input int az,
                              input int gx, input int gy, input int gz);
    imuid_pkg::imuid_in_t it;
    it.kind = imuid_pkg::KindSample;
    it.accel_x = 16'(ax);
    it.accel_y = 16'(ay);
    it.accel_z = 16'(az);
    it.gyro_x = 16'(gx);
    it.gyro_y = 16'(gy);
    it.gyro_z = 16'(gz);
    it.now_ms = clock_ms;
    offer(it);
  endtask

  function automatic int near(input int center, input int spread);
    return center - spread + int'($urandom_range(0, 2 * spread));
  endfunction

  function automatic int any_raw();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic run_directed();
    // hit flag already set just after reset, then read fault marking
    offer_plain(imuid_pkg::KindReport, 32'd0);
    offer_plain(imuid_pkg::KindFault, 32'd1);
    offer_plain(imuid_pkg::KindReport, 32'd499);
    offer_plain(imuid_pkg::KindReport, 32'd500);
    // full-scale vectors, then a drop to zero that registers a hit
    clock_ms = 32'd1000;
    offer_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    clock_ms = 32'd1002;
    offer_sample(32767, 32767, 32767, 32767, 32767, 32767);
    clock_ms = 32'd1004;
    offer_sample(0, 0, 0, 0, 0, 0);
    offer_plain(imuid_pkg::KindUnused, 32'hFFFF_FFFF);
    offer_plain(imuid_pkg::KindReport, 32'd1503);
    offer_plain(imuid_pkg::KindReport, 32'd1504);
    // hit time just before the millisecond counter wraps
    clock_ms = 32'hFFFF_FFF0;
    offer_sample(2048, 0, 0, 0, 0, 0);
    clock_ms = 32'hFFFF_FFF8;
    offer_sample(0, 0, -32768, 100, -100, 0);
    offer_plain(imuid_pkg::KindReport, 32'h0000_0010);
    clock_ms = 32'h0000_0020;
    offer_sample(0, 0, 0, 32767, 0, 0);
    offer_plain(imuid_pkg::KindReport, 32'hFFFF_FFFF);
    offer_plain(imuid_pkg::KindFault, 32'd0);
    offer_plain(imuid_pkg::KindFault, 32'd0);
    offer_plain(imuid_pkg::KindReport, 32'h0000_0030);
    // jerk and rotation right at their thresholds do not count
    clock_ms = 32'd5000;
    offer_sample(6144, 0, 0, 0, 0, 0);
    offer_sample(0, 0, 0, 0, 0, 0);
    offer_sample(6145, 0, 0, 9825, 0, 0);
    offer_sample(0, 0, 0, 9824, 0, 0);
    offer_plain(imuid_pkg::KindReport, 32'd5000);
  endtask

  // a run of samples closed by a report, with some noise mixed in
  task automatic queue_window();
    int n, r;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      clock_ms += $urandom_range(1, 4);
      if (r < 4) begin
        offer_plain(imuid_pkg::KindFault, clock_ms);
      end else if (r < 6) begin
        offer_plain(imuid_pkg::KindUnused, $urandom);
      end else if (r < 14) begin
        offer_plain(imuid_pkg::KindSample, ($urandom_range(0, 3) == 0) ? $urandom : clock_ms);
      end else if (r < 26) begin
        offer_sample(any_raw(), any_raw(), any_raw(),
                     near(0, 4000), near(0, 4000), near(0, 4000));
      end else begin
        offer_sample(near(0, 400), near(0, 400),
                     near(($urandom_range(0, 1) != 0) ? 2048 : -2048, 400),
                     near(0, 2000), near(0, 2000), near(0, 2000));
      end
    end
    if ($urandom_range(0, 2) == 0) clock_ms += $urandom_range(0, 1200);
    offer_plain(imuid_pkg::KindReport, ($urandom_range(0, 19) == 0) ? $urandom : clock_ms);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int target;
    logic [MagW-1:0] jerk_set, rotation_set;
    logic [HoldW-1:0] hold_set;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    drain();
    for (int p = 1; p <= PhaseCount; p++) begin
      case (p)
        1: begin
          jerk_set = '0;
          rotation_set = '1;
          hold_set = '1;
        end
        2: begin
          jerk_set = '1;
          rotation_set = '0;
          hold_set = '0;
        end
        5: begin
          jerk_set = imuid_pkg::JerkThresholdReset;
          rotation_set = imuid_pkg::RotationThresholdReset;
          hold_set = imuid_pkg::HitHoldMsReset;
        end
        default: begin
          jerk_set = MagW'($urandom_range(0, 24'h40_0000));
          rotation_set = MagW'($urandom_range(0, 24'h40_0000));
          hold_set = HoldW'($urandom_range(0, 1500));
        end
      endcase
      // upper data bits of the hold register are don't-care
      write_reg(imuid_pkg::CfgJerkThreshold, jerk_set);
      write_reg(imuid_pkg::CfgRotationThreshold, rotation_set);
      write_reg(imuid_pkg::CfgHitHoldMs, {8'($urandom), hold_set});
      if (p == 1) write_reg(CfgUnused, MagW'($urandom));
      idle_on = (p != 3);
      clock_ms = (p == 4) ? 32'hFFFF_F000 : $urandom;
      if (p == 2) begin
        // hold off the receiver while reports pile up at the input
        hold_asked++;
        repeat (12) offer_plain(imuid_pkg::KindReport, clock_ms);
      end
      target = items_made + ItemsPerPhase;
      while (items_made < target) queue_window();
      drain();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
